>>> src/pss_pkg.sv
// Package for the paired sample statistics block: item and result word types,
// statistic codes and fixed widths. No dependencies; the top, pss_acc and pss_fin use it.
package pss_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W = 24;
  localparam int RESULT_W = 64;
  localparam int MODE_W   = 3;

  // Default depth of the x sample store.
  localparam int DEFAULT_MAX_PAIRS = 1024;

  // Statistic codes held in the mode register.
  localparam logic [MODE_W-1:0] MODE_CORREL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RSQ      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLOPE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ICEPT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COV_POP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COV_SAMP = 3'd5;

  // Status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  // Fraction alignment of each statistic before the divide.
  localparam int SHIFT_CORREL = 64;
  localparam int SHIFT_RSQ    = 32;
  localparam int SHIFT_SLOPE  = 32;
  localparam int SHIFT_ICEPT  = 20;
  localparam int SHIFT_COV    = 8;

  // Input word.
  typedef struct packed {
    logic                       list_sel;
    logic                       is_number;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } item_t;

  // Result word.
  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       status;
    logic                       saturated;
  } stat_t;

endpackage

>>> src/paired_sample_statistics_top.sv
// Top level of the paired sample statistics block: handshakes, mode register,
// output register. Depends on pss_pkg, pss_acc and pss_fin.
//
//   Channel  Handshake              Payload            Use
//   item     item_valid/item_ready  item_data  item_t   x and y samples in
//   stat     stat_valid/stat_ready  stat_data  stat_t   one word per call
//   cfg      cfg_valid/cfg_ready    cfg_mode   3 bits   statistic select
//
// An x word or a skipped word is handled in the idle state; a paired y word
// also passes through a fetch and the bit-serial moment accumulator (one multiplier bit per cycle).
// A last word adds the finishing pass: up to 8 serial products, a divide and,
// for the correlation, a root. Reset is synchronous and needs no clearing pass.
// A stalled stat word waits in the output register while the next call's
// words are taken.
module paired_sample_statistics_top #(
  parameter int MAX_PAIRS = pss_pkg::DEFAULT_MAX_PAIRS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  pss_pkg::item_t             item_data,
  output logic                       stat_valid,
  input  logic                       stat_ready,
  output pss_pkg::stat_t             stat_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pss_pkg::MODE_W-1:0] cfg_mode
);

  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int S1W = pss_pkg::SAMPLE_W + CW;
  localparam int S2W = 2 * pss_pkg::SAMPLE_W + CW;

  logic [pss_pkg::MODE_W-1:0] mode;
  logic                  accept;
  logic                  acc_idle, call_end;
  logic [CW-1:0]         n;
  logic signed [S1W-1:0] sum_x, sum_y;
  logic signed [S2W-1:0] sum_xx, sum_yy, sum_xy;
  logic                  fin_busy, fin_valid, fin_take;
  pss_pkg::stat_t        fin_res;

  // Mode register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= pss_pkg::MODE_CORREL;
    end else if (cfg_valid) begin
      mode <= cfg_mode;
    end
  end

  // A word is taken when the accumulator is free and no result is pending.
  assign item_ready = acc_idle && !fin_busy;
  assign accept     = item_valid && item_ready;

  pss_acc #(.MAX_PAIRS(MAX_PAIRS)) u_acc (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .item     (item_data),
    .idle     (acc_idle),
    .call_end (call_end),
    .n        (n),
    .sum_x    (sum_x),
    .sum_y    (sum_y),
    .sum_xx   (sum_xx),
    .sum_yy   (sum_yy),
    .sum_xy   (sum_xy)
  );

  pss_fin #(.MAX_PAIRS(MAX_PAIRS)) u_fin (
    .clk       (clk),
    .rst       (rst),
    .start     (call_end),
    .mode      (mode),
    .n         (n),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .sum_xx    (sum_xx),
    .sum_yy    (sum_yy),
    .sum_xy    (sum_xy),
    .busy      (fin_busy),
    .res_valid (fin_valid),
    .res       (fin_res),
    .res_take  (fin_take)
  );

  // Output register.
  assign fin_take = fin_valid && (!stat_valid || stat_ready);
  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= 1'b0;
    end else if (fin_take) begin
      stat_valid <= 1'b1;
    end else if (stat_ready) begin
      stat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      stat_data <= fin_res;
    end
  end

endmodule

>>> src/pss_acc.sv
// Sample store and bit-serial moment accumulator of the statistics block.
// Depends on pss_pkg for the input word type and sample width.
module pss_acc #(
  parameter int MAX_PAIRS = pss_pkg::DEFAULT_MAX_PAIRS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  pss_pkg::item_t        item,
  output logic                  idle,
  output logic                  call_end,
  output logic [$clog2(MAX_PAIRS+1)-1:0] n,
  output logic signed [pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_x,
  output logic signed [pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_y,
  output logic signed [2*pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_xx,
  output logic signed [2*pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_yy,
  output logic signed [2*pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_xy
);

  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int AI  = $clog2(MAX_PAIRS);
  localparam int DW  = pss_pkg::SAMPLE_W;
  localparam int S1W = DW + CW;
  localparam int S2W = 2 * DW + CW;
  localparam int BW  = $clog2(DW);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_MAC, ST_END} state_t;

  state_t              state;
  logic [CW-1:0]       x_count;
  logic [CW-1:0]       pair_count;
  logic                last_r;
  logic [DW-1:0]       y_r;
  logic [DW-1:0]       rd_q;
  logic [DW-1:0]       x_store [MAX_PAIRS];
  logic                mem_we;
  logic signed [S2W-1:0] xs, ys;
  logic [DW-1:0]       xb, yb;
  logic [BW-1:0]       bitn;
  logic                top_bit;
  logic signed [S2W-1:0] t_xx, t_yy, t_xy;
  logic signed [S2W-1:0] sum_xx_next, sum_yy_next, sum_xy_next;

  assign idle     = (state == ST_IDLE);
  assign call_end = (state == ST_END);
  assign n        = pair_count;

  // An x word is stored while the store has room.
  assign mem_we = (state == ST_IDLE) && start && item.is_number && !item.list_sel &&
                  (x_count < CW'(MAX_PAIRS));

  // Sample store with registered read at the next pair position.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_store[x_count[AI-1:0]] <= item.sample;
    end
    rd_q <= x_store[pair_count[AI-1:0]];
  end

  // One multiplier bit per cycle; the sign bit weighs negative.
  assign top_bit = (bitn == BW'(DW - 1));
  assign t_xx = xb[0] ? xs : '0;
  assign t_yy = yb[0] ? ys : '0;
  assign t_xy = yb[0] ? xs : '0;
  assign sum_xx_next = top_bit ? sum_xx - t_xx : sum_xx + t_xx;
  assign sum_yy_next = top_bit ? sum_yy - t_yy : sum_yy + t_yy;
  assign sum_xy_next = top_bit ? sum_xy - t_xy : sum_xy + t_xy;

  // Sequencer and sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      x_count    <= '0;
      pair_count <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_xx     <= '0;
      sum_yy     <= '0;
      sum_xy     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            last_r <= item.last;
            y_r    <= item.sample;
            if (mem_we) begin
              x_count <= x_count + 1'b1;
            end
            if (item.is_number && item.list_sel && (pair_count < x_count)) begin
              state <= ST_FETCH;
            end else if (item.last) begin
              state <= ST_END;
            end
          end
        end
        ST_FETCH: begin
          xs         <= S2W'($signed(rd_q));
          ys         <= S2W'($signed(y_r));
          xb         <= rd_q;
          yb         <= y_r;
          bitn       <= '0;
          sum_x      <= sum_x + S1W'($signed(rd_q));
          sum_y      <= sum_y + S1W'($signed(y_r));
          pair_count <= pair_count + 1'b1;
          state      <= ST_MAC;
        end
        ST_MAC: begin
          sum_xx <= sum_xx_next;
          sum_yy <= sum_yy_next;
          sum_xy <= sum_xy_next;
          xs     <= xs <<< 1;
          ys     <= ys <<< 1;
          xb     <= xb >> 1;
          yb     <= yb >> 1;
          bitn   <= bitn + 1'b1;
          if (top_bit) begin
            state <= last_r ? ST_END : ST_IDLE;
          end
        end
        ST_END: begin
          x_count    <= '0;
          pair_count <= '0;
          sum_x      <= '0;
          sum_y      <= '0;
          sum_xx     <= '0;
          sum_yy     <= '0;
          sum_xy     <= '0;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pairs never outrun stored x values.
  a_pair_le_x: assert property (@(posedge clk) disable iff (rst)
    pair_count <= x_count) else $error("pair count exceeds x count");

  // The store never overfills.
  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    x_count <= CW'(MAX_PAIRS)) else $error("x count beyond store depth");

  // Accumulation only runs on a counted pair.
  a_mac_counted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (pair_count != '0)) else $error("accumulating without a pair");

endmodule

>>> src/pss_mul.sv
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; used by the finishing sequencer.
module pss_mul #(
  parameter int AW = 72
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [AW-1:0]   b,
  output logic            done,
  output logic [2*AW-1:0] p
);

  localparam int PW = 2 * AW;
  localparam int CNW = $clog2(AW + 1);

  logic [PW-1:0]  mc;
  logic [AW-1:0]  mp;
  logic [PW-1:0]  acc;
  logic [CNW-1:0] cnt;
  logic           busy;

  assign p = acc;

  // Add the shifted multiplicand when the current multiplier bit is set.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mc   <= PW'(a);
        mp   <= b;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (mp[0]) begin
          acc <= acc + mc;
        end
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == CNW'(AW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/pss_div.sv
// Restoring divider, one quotient bit per cycle, keeping the low quotient bits
// and a flag for any higher bit. Depends on nothing; used by the sequencer.
module pss_div #(
  parameter int DW = 144,
  parameter int NW = 208,
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quot,
  output logic          over
);

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  nd;
  logic [DW-1:0]  rem;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [DW:0]    r2;
  logic [DW:0]    dsub;
  logic           ge;

  // Trial subtract of the divisor from the shifted remainder.
  assign r2   = {rem, nd[NW-1]};
  assign dsub = r2 - {1'b0, divisor};
  assign ge   = (r2 >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nd   <= dividend;
        rem  <= '0;
        quot <= '0;
        over <= 1'b0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? dsub[DW-1:0] : r2[DW-1:0];
        nd   <= nd << 1;
        quot <= {quot[QW-2:0], ge};
        over <= over | quot[QW-1];
        cnt  <= cnt + 1'b1;
        if (cnt == CNW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/pss_fin.sv
// Finishing sequencer: forms the moment differences, divides, takes the root
// for the correlation and clamps. Depends on pss_pkg, pss_mul and pss_div.
module pss_fin #(
  parameter int MAX_PAIRS = pss_pkg::DEFAULT_MAX_PAIRS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [pss_pkg::MODE_W-1:0] mode,
  input  logic [$clog2(MAX_PAIRS+1)-1:0] n,
  input  logic signed [pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_x,
  input  logic signed [pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_y,
  input  logic signed [2*pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_xx,
  input  logic signed [2*pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_yy,
  input  logic signed [2*pss_pkg::SAMPLE_W+$clog2(MAX_PAIRS+1)-1:0] sum_xy,
  output logic                  busy,
  output logic                  res_valid,
  output pss_pkg::stat_t        res,
  input  logic                  res_take
);

  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int S1W = pss_pkg::SAMPLE_W + CW;
  localparam int S2W = 2 * pss_pkg::SAMPLE_W + CW;
  localparam int AW  = 2 * pss_pkg::SAMPLE_W + 2 + 2 * CW;
  localparam int PW  = 2 * AW;
  localparam int RW  = pss_pkg::RESULT_W;
  localparam int NW  = PW + RW;
  localparam logic [RW-1:0] POS_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0] NEG_MIN = {1'b1, {(RW-1){1'b0}}};
  localparam logic [RW-1:0] ROOT_ONE = RW'(1) << (RW / 2);
  localparam logic [RW-1:0] ROOT_TOP = RW'(1) << (RW - 2);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_SQRT, ST_PACK, ST_HOLD
  } state_t;

  typedef enum logic [3:0] {
    OP_N, OP_M, OP_SX, OP_SY, OP_SXX, OP_SYY, OP_SXY, OP_VA, OP_VB, OP_VC
  } opnd_t;

  typedef enum logic [1:0] {DST_VA, DST_VB, DST_VC} dst_t;

  typedef struct packed {
    logic  stop;
    opnd_t a;
    opnd_t b;
    dst_t  dst;
    logic  sub;
    logic  keep;
  } step_t;

  // Product program for each statistic: A, B, C, the intercept numerator, the
  // covariance divisor, and the products the correlation and r-squared need.
  function automatic step_t prog(logic [pss_pkg::MODE_W-1:0] md, logic [3:0] idx);
    step_t s;
    s = '{stop: 1'b1, a: OP_N, b: OP_N, dst: DST_VA, sub: 1'b0, keep: 1'b0};
    if (md == pss_pkg::MODE_CORREL || md == pss_pkg::MODE_RSQ) begin
      unique case (idx)
        4'd0: s = '{1'b0, OP_N,  OP_SXX, DST_VA, 1'b0, 1'b0};
        4'd1: s = '{1'b0, OP_SX, OP_SX,  DST_VA, 1'b1, 1'b0};
        4'd2: s = '{1'b0, OP_N,  OP_SYY, DST_VB, 1'b0, 1'b0};
        4'd3: s = '{1'b0, OP_SY, OP_SY,  DST_VB, 1'b1, 1'b0};
        4'd4: s = '{1'b0, OP_N,  OP_SXY, DST_VC, 1'b0, 1'b0};
        4'd5: s = '{1'b0, OP_SX, OP_SY,  DST_VC, 1'b1, md == pss_pkg::MODE_CORREL};
        4'd6: s = '{1'b0, OP_VC, OP_VC,  DST_VC, 1'b0, 1'b0};
        4'd7: s = '{1'b0, OP_VA, OP_VB,  DST_VA, 1'b0, 1'b0};
        default: s.stop = 1'b1;
      endcase
    end else if (md == pss_pkg::MODE_SLOPE) begin
      unique case (idx)
        4'd0: s = '{1'b0, OP_N,  OP_SXX, DST_VA, 1'b0, 1'b0};
        4'd1: s = '{1'b0, OP_SX, OP_SX,  DST_VA, 1'b1, 1'b0};
        4'd2: s = '{1'b0, OP_N,  OP_SXY, DST_VC, 1'b0, 1'b0};
        4'd3: s = '{1'b0, OP_SX, OP_SY,  DST_VC, 1'b1, 1'b1};
        default: s.stop = 1'b1;
      endcase
    end else if (md == pss_pkg::MODE_ICEPT) begin
      unique case (idx)
        4'd0: s = '{1'b0, OP_N,  OP_SXX, DST_VA, 1'b0, 1'b0};
        4'd1: s = '{1'b0, OP_SX, OP_SX,  DST_VA, 1'b1, 1'b0};
        4'd2: s = '{1'b0, OP_SY, OP_SXX, DST_VB, 1'b0, 1'b0};
        4'd3: s = '{1'b0, OP_SX, OP_SXY, DST_VB, 1'b1, 1'b1};
        default: s.stop = 1'b1;
      endcase
    end else begin
      unique case (idx)
        4'd0: s = '{1'b0, OP_N,  OP_SXY, DST_VC, 1'b0, 1'b0};
        4'd1: s = '{1'b0, OP_SX, OP_SY,  DST_VC, 1'b1, 1'b1};
        4'd2: s = '{1'b0, OP_N,  OP_M,   DST_VA, 1'b0, 1'b0};
        default: s.stop = 1'b1;
      endcase
    end
    return s;
  endfunction

  state_t                 state;
  logic [pss_pkg::MODE_W-1:0] mode_r;
  logic [CW-1:0]          n_r, m_r;
  logic signed [S1W-1:0]  sx_r, sy_r;
  logic signed [S2W-1:0]  sxx_r, syy_r, sxy_r;
  logic signed [PW-1:0]   va, vb, vc;
  logic [3:0]             step;
  logic                   neg, err, mul_neg;
  logic [RW-1:0]          mag;
  logic                   mag_over;
  logic [RW-1:0]          sq_x, sq_res, sq_bit;
  pss_pkg::stat_t         res_r;

  step_t                  cur;
  logic signed [PW-1:0]   opa, opb, mag_a, mag_b;
  logic                   mul_start, mul_done;
  logic [PW-1:0]          mul_p;
  logic signed [PW-1:0]   prod, dst_old, dst_new;
  logic signed [PW-1:0]   dvd_src;
  logic [PW-1:0]          dvd_mag;
  logic [NW-1:0]          dividend;
  logic                   div_start, div_done, div_over;
  logic [RW-1:0]          div_q;
  logic [RW-1:0]          sq_try, sq_x_next, sq_res_next;

  assign cur = prog(mode_r, step);

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cur.a)
      OP_N:    opa = PW'(n_r);
      OP_M:    opa = PW'(m_r);
      OP_SX:   opa = PW'(sx_r);
      OP_SY:   opa = PW'(sy_r);
      OP_SXX:  opa = PW'(sxx_r);
      OP_SYY:  opa = PW'(syy_r);
      OP_SXY:  opa = PW'(sxy_r);
      OP_VA:   opa = va;
      OP_VB:   opa = vb;
      OP_VC:   opa = vc;
      default: opa = '0;
    endcase
    unique case (cur.b)
      OP_N:    opb = PW'(n_r);
      OP_M:    opb = PW'(m_r);
      OP_SX:   opb = PW'(sx_r);
      OP_SY:   opb = PW'(sy_r);
      OP_SXX:  opb = PW'(sxx_r);
      OP_SYY:  opb = PW'(syy_r);
      OP_SXY:  opb = PW'(sxy_r);
      OP_VA:   opb = va;
      OP_VB:   opb = vb;
      OP_VC:   opb = vc;
      default: opb = '0;
    endcase
    unique case (cur.dst)
      DST_VA:  dst_old = va;
      DST_VB:  dst_old = vb;
      DST_VC:  dst_old = vc;
      default: dst_old = '0;
    endcase
  end

  // Magnitudes go to the multiplier; the sign is applied to its product.
  assign mag_a     = opa[PW-1] ? -opa : opa;
  assign mag_b     = opb[PW-1] ? -opb : opb;
  assign mul_start = (state == ST_MUL_GO) && !cur.stop;
  assign prod      = mul_neg ? -$signed(mul_p) : $signed(mul_p);
  assign dst_new   = cur.sub ? dst_old - prod : prod;

  pss_mul #(.AW(AW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mag_a[AW-1:0]),
    .b     (mag_b[AW-1:0]),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Dividend: magnitude of the numerator aligned to the result fraction.
  assign dvd_src = (mode_r == pss_pkg::MODE_ICEPT) ? vb : vc;
  assign dvd_mag = dvd_src[PW-1] ? PW'(-dvd_src) : PW'(dvd_src);
  always_comb begin
    unique case (mode_r)
      pss_pkg::MODE_CORREL: dividend = NW'(dvd_mag) << pss_pkg::SHIFT_CORREL;
      pss_pkg::MODE_RSQ:    dividend = NW'(dvd_mag) << pss_pkg::SHIFT_RSQ;
      pss_pkg::MODE_SLOPE:  dividend = NW'(dvd_mag) << pss_pkg::SHIFT_SLOPE;
      pss_pkg::MODE_ICEPT:  dividend = NW'(dvd_mag) << pss_pkg::SHIFT_ICEPT;
      default:              dividend = NW'(dvd_mag) << pss_pkg::SHIFT_COV;
    endcase
  end
  assign div_start = (state == ST_DIV_GO) && (va != '0);

  pss_div #(.DW(PW), .NW(NW), .QW(RW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (va),
    .done     (div_done),
    .quot     (div_q),
    .over     (div_over)
  );

  // One step of the digit-by-digit square root.
  assign sq_try      = sq_res + sq_bit;
  assign sq_x_next   = (sq_x >= sq_try) ? sq_x - sq_try : sq_x;
  assign sq_res_next = (sq_x >= sq_try) ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_HOLD);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            mode_r   <= mode;
            n_r      <= n;
            m_r      <= (mode == pss_pkg::MODE_COV_SAMP) ? n - 1'b1 : n;
            sx_r     <= sum_x;
            sy_r     <= sum_y;
            sxx_r    <= sum_xx;
            syy_r    <= sum_yy;
            sxy_r    <= sum_xy;
            step     <= '0;
            neg      <= 1'b0;
            err      <= 1'b0;
            mag      <= '0;
            mag_over <= 1'b0;
            if ((n < CW'(2)) || (mode > pss_pkg::MODE_COV_SAMP)) begin
              err   <= 1'b1;
              state <= ST_PACK;
            end else begin
              state <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: begin
          if (cur.stop) begin
            state <= ST_DIV_GO;
          end else begin
            mul_neg <= opa[PW-1] ^ opb[PW-1];
            state   <= ST_MUL_WAIT;
          end
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            unique case (cur.dst)
              DST_VA:  va <= dst_new;
              DST_VB:  vb <= dst_new;
              default: vc <= dst_new;
            endcase
            if (cur.keep) begin
              neg <= dst_new[PW-1];
            end
            step  <= step + 1'b1;
            state <= ST_MUL_GO;
          end
        end
        ST_DIV_GO: begin
          // A zero divisor means zero variance.
          if (va == '0) begin
            err   <= 1'b1;
            state <= ST_PACK;
          end else begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (mode_r == pss_pkg::MODE_CORREL) begin
              if (div_over) begin
                mag   <= ROOT_ONE;
                state <= ST_PACK;
              end else begin
                sq_x   <= div_q;
                sq_res <= '0;
                sq_bit <= ROOT_TOP;
                state  <= ST_SQRT;
              end
            end else begin
              mag      <= div_q;
              mag_over <= div_over;
              state    <= ST_PACK;
            end
          end
        end
        ST_SQRT: begin
          sq_x   <= sq_x_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            mag   <= sq_res_next;
            state <= ST_PACK;
          end
        end
        ST_PACK: begin
          // Sign and clamp to the result range.
          res_r.status    <= err ? pss_pkg::STATUS_DIV_ZERO : pss_pkg::STATUS_OK;
          res_r.saturated <= 1'b0;
          res_r.result    <= '0;
          if (!err && (mag_over || mag != '0)) begin
            if (!neg) begin
              if (mag_over || mag[RW-1]) begin
                res_r.result    <= POS_MAX;
                res_r.saturated <= 1'b1;
              end else begin
                res_r.result <= mag;
              end
            end else begin
              if (mag_over || mag > NEG_MIN) begin
                res_r.result    <= NEG_MIN;
                res_r.saturated <= 1'b1;
              end else begin
                res_r.result <= -mag;
              end
            end
          end
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An error word carries a zero result and no clamp flag.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == pss_pkg::STATUS_DIV_ZERO) |->
    (res.result == '0 && !res.saturated)) else $error("error word not clean");

  // A clamped result sits on one of the range bounds.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.saturated) |->
    (res.result == POS_MAX || res.result == NEG_MIN)) else $error("clamp off bound");

  // The sequencer frees only after its word has been handed over.
  a_free_after_take: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(res_take)) else $error("result dropped");

endmodule
